@@ src/lmfs_pkg.sv @@
// Shared types and constants of the LED matrix frame scanner.
package lmfs_pkg;

    // Widths of the configuration index and data fields.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_ROWS    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMNS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROTATE  = 2'd2;

    // Operation codes carried by an input transaction.
    typedef enum logic [3:0] {
        OP_TICK        = 4'd0,
        OP_LOAD_ROW    = 4'd1,
        OP_CLEAR       = 4'd2,
        OP_ROTATE_COLS = 4'd3,
        OP_ROTATE_ROWS = 4'd4,
        OP_MIRROR_COLS = 4'd5,
        OP_MIRROR_ROWS = 4'd6,
        OP_INVERT      = 4'd7,
        OP_TOGGLE      = 4'd8
    } op_t;

    // Per-row transform applied by the datapath during a row sweep.
    typedef enum logic [2:0] {
        XF_MASK,
        XF_ROTL,
        XF_MIRROR,
        XF_INVERT,
        XF_PASS
    } xform_t;

    // One input transaction.
    typedef struct packed {
        logic [3:0]  operation;
        logic [3:0]  row_index;
        logic [15:0] row_data;
    } item_t;

    // One result transaction.
    typedef struct packed {
        logic [3:0]  line_index;
        logic [15:0] line_pattern;
        logic        rotated;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic   rd_en;
        logic   rd_scan;
        logic   emit;
        logic   wr_en;
        logic   load;
        logic   clear;
        logic   toggle;
        logic   cfg_we;
        xform_t xform;
    } cmd_t;

endpackage

@@ src/led_matrix_frame_scanner.sv @@
// LED matrix frame scanner: top level joining the controller and the datapath.
//
// The block holds a frame of up to MAX_DIM rows of lit bits and serves a
// multiplexed LED matrix. A command transaction is accepted at a clock edge
// where start is high and busy is low; item carries the operation, the row
// index and the row data for a row load.
// A scan tick holds busy in the tick state and shows its result through the
// tick state and the result register, as a one-cycle strobe on result_valid
// with the line index, the lit pattern (one means lit) and the rotated flag.
// The receiver cannot stall: the result is taken in the cycle it is shown.
// Row load, clear, orientation toggle and unknown codes leave busy low, so a
// new command may follow at once. Column rotate and mirror, row rotate and
// mirror, and invert sweep the rows in use through the one-write, one-read
// frame RAM, one row read and one row written per cycle. The configuration
// channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is ready only while the
// block is idle and start is low. Writing columns_in_use masks every stored
// row, a sweep over all MAX_DIM rows. Reset clears the frame through per-row
// valid bits, so no clearing pass runs; the scan starts at row zero with eight
// rows and eight columns in use, or MAX_DIM of each if that is smaller.
module led_matrix_frame_scanner
    import lmfs_pkg::*;
#(
    parameter int MAX_DIM = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  item_t                  item,
    output result_t                result,
    output logic                   result_valid,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = $clog2(MAX_DIM);
    localparam int DIM_W = $clog2(MAX_DIM + 1);

    cmd_t             cmd;
    logic [AW-1:0]    seq_rd_addr;
    logic [AW-1:0]    seq_wr_addr;
    logic [DIM_W-1:0] rows;

    lmfs_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (item.operation),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .rows      (rows),
        .busy      (busy),
        .cfg_ready (cfg_ready),
        .cmd       (cmd),
        .rd_addr   (seq_rd_addr),
        .wr_addr   (seq_wr_addr)
    );

    lmfs_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .seq_rd_addr  (seq_rd_addr),
        .seq_wr_addr  (seq_wr_addr),
        .item         (item),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .rows         (rows),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

@@ src/lmfs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lmfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/lmfs_ctrl.sv @@
// Controller of the frame scanner: command decode and the row sweep sequencer.
module lmfs_ctrl
    import lmfs_pkg::*;
#(
    parameter int MAX_DIM = 16,
    localparam int AW = $clog2(MAX_DIM),
    localparam int DIM_W = $clog2(MAX_DIM + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [3:0]             operation,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]       rows,
    output logic                   busy,
    output logic                   cfg_ready,
    output cmd_t                   cmd,
    output logic [AW-1:0]          rd_addr,
    output logic [AW-1:0]          wr_addr
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_SEQ
    } state_t;

    // Order in which the sweep reads rows.
    typedef enum logic {
        RD_ASCEND,
        RD_ALTERNATE
    } rd_order_t;

    // Where the row read on the previous sweep step is written back.
    typedef enum logic [1:0] {
        WR_SAME,
        WR_NEXT,
        WR_FLIP
    } wr_place_t;

    state_t            state_reg, state_next;
    logic              busy_reg, busy_next;
    xform_t            xform_reg, xform_next;
    rd_order_t         order_reg, order_next;
    wr_place_t         place_reg, place_next;
    logic [DIM_W-1:0]  count_reg, count_next;
    logic [DIM_W-1:0]  step_reg, step_next;
    logic [AW-1:0]     prev_reg, prev_next;
    logic              prev_v_reg, prev_v_next;

    logic              accept;
    logic [DIM_W-1:0]  half;
    logic [DIM_W-1:0]  prev_inc;
    logic [AW-1:0]     seq_rd_addr;
    logic [AW-1:0]     seq_wr_addr;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    // Read address of the current sweep step.
    always_comb
    begin
        half = step_reg >> 1;
        if (order_reg == RD_ALTERNATE && step_reg[0])
        begin
            seq_rd_addr = AW'(count_reg - 1'b1 - half);
        end
        else if (order_reg == RD_ALTERNATE)
        begin
            seq_rd_addr = AW'(half);
        end
        else
        begin
            seq_rd_addr = AW'(step_reg);
        end
    end

    // Write address for the row that was read on the previous step.
    always_comb
    begin
        prev_inc = DIM_W'(prev_reg) + 1'b1;
        case (place_reg)
            WR_SAME:
            begin
                seq_wr_addr = prev_reg;
            end
            WR_NEXT:
            begin
                seq_wr_addr = (prev_inc == count_reg) ? '0 : AW'(prev_inc);
            end
            WR_FLIP:
            begin
                seq_wr_addr = AW'(count_reg - 1'b1 - DIM_W'(prev_reg));
            end
            default:
            begin
                seq_wr_addr = prev_reg;
            end
        endcase
    end

    // Next state and command decode.
    always_comb
    begin
        state_next  = state_reg;
        busy_next   = busy_reg;
        xform_next  = xform_reg;
        order_next  = order_reg;
        place_next  = place_reg;
        count_next  = count_reg;
        step_next   = step_reg;
        prev_next   = prev_reg;
        prev_v_next = prev_v_reg;
        cmd         = '0;
        cmd.xform   = XF_PASS;
        rd_addr     = '0;
        wr_addr     = '0;
        cfg_ready   = (state_reg == ST_IDLE) && !start;

        case (state_reg)
            ST_IDLE:
            begin
                step_next   = '0;
                prev_v_next = 1'b0;
                count_next  = rows;
                order_next  = RD_ASCEND;
                place_next  = WR_SAME;
                if (accept)
                begin
                    case (operation)
                        OP_TICK:
                        begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_scan = 1'b1;
                            state_next  = ST_TICK;
                            busy_next   = 1'b1;
                        end
                        OP_LOAD_ROW:
                        begin
                            cmd.load = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                        end
                        OP_ROTATE_COLS:
                        begin
                            xform_next = XF_ROTL;
                            state_next = ST_SEQ;
                            busy_next  = 1'b1;
                        end
                        OP_ROTATE_ROWS:
                        begin
                            xform_next = XF_PASS;
                            place_next = WR_NEXT;
                            state_next = ST_SEQ;
                            busy_next  = 1'b1;
                        end
                        OP_MIRROR_COLS:
                        begin
                            xform_next = XF_MIRROR;
                            state_next = ST_SEQ;
                            busy_next  = 1'b1;
                        end
                        OP_MIRROR_ROWS:
                        begin
                            xform_next = XF_PASS;
                            order_next = RD_ALTERNATE;
                            place_next = WR_FLIP;
                            state_next = ST_SEQ;
                            busy_next  = 1'b1;
                        end
                        OP_INVERT:
                        begin
                            xform_next = XF_INVERT;
                            state_next = ST_SEQ;
                            busy_next  = 1'b1;
                        end
                        OP_TOGGLE:
                        begin
                            cmd.toggle = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (cfg_valid && cfg_ready)
                begin
                    cmd.cfg_we = 1'b1;
                    // A new column width masks every stored row.
                    if (cfg_index == REG_COLUMNS)
                    begin
                        xform_next = XF_MASK;
                        count_next = DIM_W'(MAX_DIM);
                        state_next = ST_SEQ;
                        busy_next  = 1'b1;
                    end
                end
            end

            ST_TICK:
            begin
                cmd.emit   = 1'b1;
                state_next = ST_IDLE;
                busy_next  = 1'b0;
            end

            ST_SEQ:
            begin
                cmd.xform = xform_reg;
                cmd.wr_en = prev_v_reg;
                wr_addr   = seq_wr_addr;
                if (step_reg < count_reg)
                begin
                    cmd.rd_en   = 1'b1;
                    rd_addr     = seq_rd_addr;
                    step_next   = step_reg + 1'b1;
                    prev_next   = seq_rd_addr;
                    prev_v_next = 1'b1;
                end
                else
                begin
                    prev_v_next = 1'b0;
                    state_next  = ST_IDLE;
                    busy_next   = 1'b0;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            busy_reg   <= 1'b0;
            xform_reg  <= XF_PASS;
            order_reg  <= RD_ASCEND;
            place_reg  <= WR_SAME;
            count_reg  <= '0;
            step_reg   <= '0;
            prev_reg   <= '0;
            prev_v_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            busy_reg   <= busy_next;
            xform_reg  <= xform_next;
            order_reg  <= order_next;
            place_reg  <= place_next;
            count_reg  <= count_next;
            step_reg   <= step_next;
            prev_reg   <= prev_next;
            prev_v_reg <= prev_v_next;
        end
    end

endmodule

@@ src/lmfs_datapath.sv @@
// Datapath of the frame scanner: frame store, row transforms, scan and result.
module lmfs_datapath
    import lmfs_pkg::*;
#(
    parameter int MAX_DIM = 16,
    localparam int AW = $clog2(MAX_DIM),
    localparam int DIM_W = $clog2(MAX_DIM + 1),
    localparam int ROW_W = MAX_DIM
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    input  logic [AW-1:0]          seq_rd_addr,
    input  logic [AW-1:0]          seq_wr_addr,
    input  item_t                  item,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic [DIM_W-1:0]       rows,
    output result_t                result,
    output logic                   result_valid
);

    localparam int DIM_RESET = (8 > MAX_DIM) ? MAX_DIM : 8;

    logic [DIM_W-1:0]   rows_reg, rows_next;
    logic [DIM_W-1:0]   cols_reg, cols_next;
    logic               rot_init_reg, rot_init_next;
    logic               tog_reg, tog_next;
    logic [AW-1:0]      scan_reg, scan_next;
    logic [MAX_DIM-1:0] valid_reg, valid_next;
    logic               result_valid_reg, result_valid_next;
    logic [AW-1:0]      line_reg;
    logic               rd_valid_reg;
    result_t            result_reg;

    logic [DIM_W-1:0]   cfg_dim;
    logic [AW-1:0]      scan_sel;
    logic [DIM_W-1:0]   line_inc;
    logic [ROW_W-1:0]   col_mask;
    logic [ROW_W-1:0]   ram_q;
    logic [ROW_W-1:0]   rd_word;
    logic [ROW_W-1:0]   masked;
    logic [ROW_W-1:0]   rotl_word;
    logic [ROW_W-1:0]   mirror_word;
    logic [ROW_W-1:0]   xform_word;
    logic [ROW_W-1:0]   load_word;
    logic [AW-1:0]      top_bit;
    logic [DIM_W-1:0]   src_bit;
    logic               load_hit;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ROW_W-1:0]   ram_wdata;
    logic [AW-1:0]      ram_raddr;

    assign rows = rows_reg;

    // Size register value: zero counts as one, anything above the array size saturates.
    always_comb
    begin
        if (cfg_data == '0)
        begin
            cfg_dim = DIM_W'(1);
        end
        else if (32'(cfg_data) > MAX_DIM)
        begin
            cfg_dim = DIM_W'(MAX_DIM);
        end
        else
        begin
            cfg_dim = DIM_W'(cfg_data);
        end
    end

    // Column mask from the column width.
    always_comb
    begin
        for (int b = 0; b < ROW_W; b++)
        begin
            col_mask[b] = (DIM_W'(b) < cols_reg);
        end
    end

    // Scan position, taken as zero when it lies beyond the rows in use.
    assign scan_sel = (DIM_W'(scan_reg) >= rows_reg) ? '0 : scan_reg;

    // Rows never written since reset or a clear read as zero.
    assign rd_word = rd_valid_reg ? ram_q : '0;
    assign masked  = rd_word & col_mask;

    // Column rotate left and column mirror within the column width.
    always_comb
    begin
        top_bit = AW'(cols_reg - 1'b1);
        rotl_word[0] = masked[top_bit];
        for (int b = 1; b < ROW_W; b++)
        begin
            rotl_word[b] = masked[b-1];
        end
        rotl_word = rotl_word & col_mask;

        src_bit = '0;
        for (int b = 0; b < ROW_W; b++)
        begin
            src_bit = cols_reg - 1'b1 - DIM_W'(b);
            mirror_word[b] = col_mask[b] ? masked[AW'(src_bit)] : 1'b0;
        end
    end

    // Transform selected for the row sweep.
    always_comb
    begin
        case (cmd.xform)
            XF_MASK:   xform_word = masked;
            XF_ROTL:   xform_word = rotl_word;
            XF_MIRROR: xform_word = mirror_word;
            XF_INVERT: xform_word = ~rd_word & col_mask;
            XF_PASS:   xform_word = rd_word;
            default:   xform_word = rd_word;
        endcase
    end

    // Row load, ignored beyond the rows in use.
    assign load_word = ROW_W'(item.row_data) & col_mask;
    assign load_hit  = cmd.load && (32'(item.row_index) < 32'(rows_reg));

    // Frame store port selection.
    always_comb
    begin
        ram_raddr = cmd.rd_scan ? scan_sel : seq_rd_addr;
        if (load_hit)
        begin
            ram_we    = 1'b1;
            ram_waddr = AW'(item.row_index);
            ram_wdata = load_word;
        end
        else
        begin
            ram_we    = cmd.wr_en;
            ram_waddr = seq_wr_addr;
            ram_wdata = xform_word;
        end
    end

    lmfs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_DIM)
    ) u_frame (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (cmd.rd_en),
        .rd_addr (ram_raddr),
        .rd_data (ram_q)
    );

    // Configuration, orientation, row valid bits and scan position.
    always_comb
    begin
        rows_next         = rows_reg;
        cols_next         = cols_reg;
        rot_init_next     = rot_init_reg;
        tog_next          = tog_reg;
        scan_next         = scan_reg;
        valid_next        = valid_reg;
        result_valid_next = cmd.emit;
        line_inc          = DIM_W'(line_reg) + 1'b1;

        if (cmd.cfg_we)
        begin
            if (cfg_index == REG_ROWS)
            begin
                rows_next = cfg_dim;
            end
            else if (cfg_index == REG_COLUMNS)
            begin
                cols_next = cfg_dim;
            end
            else if (cfg_index == REG_ROTATE)
            begin
                rot_init_next = cfg_data[0];
            end
        end

        if (cmd.toggle)
        begin
            tog_next = ~tog_reg;
        end

        if (cmd.clear)
        begin
            for (int i = 0; i < MAX_DIM; i++)
            begin
                if (DIM_W'(i) < rows_reg)
                begin
                    valid_next[i] = 1'b0;
                end
            end
        end

        if (ram_we)
        begin
            valid_next[ram_waddr] = 1'b1;
        end

        if (cmd.emit)
        begin
            scan_next = (line_inc == rows_reg) ? '0 : AW'(line_inc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg         <= DIM_W'(DIM_RESET);
            cols_reg         <= DIM_W'(DIM_RESET);
            rot_init_reg     <= 1'b0;
            tog_reg          <= 1'b0;
            scan_reg         <= '0;
            valid_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            rows_reg         <= rows_next;
            cols_reg         <= cols_next;
            rot_init_reg     <= rot_init_next;
            tog_reg          <= tog_next;
            scan_reg         <= scan_next;
            valid_reg        <= valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers: read validity, selected line and the result transaction.
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_valid_reg <= valid_reg[ram_raddr];
        end
        if (cmd.rd_scan)
        begin
            line_reg <= scan_sel;
        end
        if (cmd.emit)
        begin
            result_reg.line_index   <= 4'(line_reg);
            result_reg.line_pattern <= 16'(masked);
            result_reg.rotated      <= rot_init_reg ^ tog_reg;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

@@ src/lmfs_checker.sv @@
// Port-level checks of the frame scanner, bound to the top level.
module lmfs_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic result_valid,
    input logic cfg_ready
);

    // A result strobe is never directly followed by another.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe on two consecutive cycles");

    // A result follows a cycle in which the block was busy with the tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result strobe without preceding busy cycle");

    // Configuration transactions are offered only while idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !busy)
        else $error("configuration ready while busy");

    // The block only becomes busy after a command or configuration transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> ($past(start) || $past(cfg_ready)))
        else $error("busy rose without a transaction");

endmodule

bind led_matrix_frame_scanner lmfs_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .cfg_ready    (cfg_ready)
);

@@ verif/led_matrix_frame_scanner_tb.sv @@
// Self-checking testbench for the LED matrix frame scanner.
`timescale 1ns / 100ps

module led_matrix_frame_scanner_tb
    import lmfs_pkg::*;
();

    // Register index with no register behind it, and the unused operation range.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [3:0] OP_UNUSED_LO = 4'd9;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;

    localparam int NUM_PHASES      = 9;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int SETTLE_CYCLES   = 20;
    localparam int DRAIN_LIMIT     = 200;

    // Tracks the frame store and predicts the line shown on every scan tick.
    class frame_scoreboard;
        logic [15:0] frame_copy [16];
        int unsigned scan_pos;
        bit toggled;
        int unsigned rows;
        int unsigned cols;
        bit rot_init;
        result_t lines_due [$];
        int errors;

        function new();
            foreach (frame_copy[i])
                frame_copy[i] = '0;
            scan_pos = 0;
            toggled  = 1'b0;
            rows     = 8;
            cols     = 8;
            rot_init = 1'b0;
            errors   = 0;
        endfunction

        function int unsigned clamp_size(logic [CFG_DATA_W-1:0] v);
            if (v == 0)
                return 1;
            if (v > 16)
                return 16;
            return 32'(v);
        endfunction

        function logic [15:0] column_mask();
            logic [16:0] m;
            m = (17'd1 << cols) - 17'd1;
            return m[15:0];
        endfunction

        function logic [15:0] mirror_row(logic [15:0] v);
            logic [15:0] r;
            r = '0;
            for (int c = 0; c < cols; c++)
            begin
                r = {r[14:0], v[0]};
                v = v >> 1;
            end
            return r;
        endfunction

        // A columns write masks every stored row, even rows outside use.
        function void write_config(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_ROWS:
                    rows = clamp_size(val);
                REG_COLUMNS:
                begin
                    cols = clamp_size(val);
                    foreach (frame_copy[i])
                        frame_copy[i] &= column_mask();
                end
                REG_ROTATE:
                    rot_init = val[0];
                default:
                    ;
            endcase
        endfunction

        // Applies one accepted command transaction to the predicted state.
        function void note_command(item_t cmd);
            logic [15:0] mask;
            logic [15:0] t;
            result_t line;
            mask = column_mask();
            case (cmd.operation)
                OP_TICK:
                begin
                    if (scan_pos >= rows)
                        scan_pos = 0;
                    line.line_index   = scan_pos[3:0];
                    line.line_pattern = frame_copy[scan_pos[3:0]] & mask;
                    line.rotated      = rot_init ^ toggled;
                    lines_due.push_back(line);
                    scan_pos = (scan_pos + 1) % rows;
                end
                OP_LOAD_ROW:
                    if (cmd.row_index < rows)
                        frame_copy[cmd.row_index] = cmd.row_data & mask;
                OP_CLEAR:
                    for (int i = 0; i < rows; i++)
                        frame_copy[i] = '0;
                OP_ROTATE_COLS:
                    for (int i = 0; i < rows; i++)
                    begin
                        t = frame_copy[i] & mask;
                        frame_copy[i] = ((t << 1) | ((t >> (cols - 1)) & 16'h1)) & mask;
                    end
                OP_ROTATE_ROWS:
                begin
                    t = frame_copy[rows - 1];
                    for (int i = rows - 1; i > 0; i--)
                        frame_copy[i] = frame_copy[i - 1];
                    frame_copy[0] = t;
                end
                OP_MIRROR_COLS:
                    for (int i = 0; i < rows; i++)
                        frame_copy[i] = mirror_row(frame_copy[i] & mask) & mask;
                OP_MIRROR_ROWS:
                    for (int i = 0; i < rows / 2; i++)
                    begin
                        t = frame_copy[i];
                        frame_copy[i] = frame_copy[rows - 1 - i];
                        frame_copy[rows - 1 - i] = t;
                    end
                OP_INVERT:
                    for (int i = 0; i < rows; i++)
                        frame_copy[i] = ~frame_copy[i] & mask;
                OP_TOGGLE:
                    toggled = ~toggled;
                default:
                    ;
            endcase
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= 50)
                $display("mismatch at %0t: %s", $time, what);
        endtask

        // Compares one shown line with the oldest prediction.
        task check_line(result_t got);
            result_t want;
            if (lines_due.size() == 0)
            begin
                report_mismatch($sformatf("line %0d pattern %h shown with none due",
                                          got.line_index, got.line_pattern));
                return;
            end
            want = lines_due.pop_front();
            if (got.line_index !== want.line_index)
                report_mismatch($sformatf("line_index %0d, predicted %0d",
                                          got.line_index, want.line_index));
            if (got.line_pattern !== want.line_pattern)
                report_mismatch($sformatf("line_pattern %h, predicted %h on line %0d",
                                          got.line_pattern, want.line_pattern,
                                          want.line_index));
            if (got.rotated !== want.rotated)
                report_mismatch($sformatf("rotated %b, predicted %b",
                                          got.rotated, want.rotated));
        endtask

        function int pending();
            return lines_due.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    item_t item = '0;
    result_t result;
    logic result_valid;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    frame_scoreboard sb;

    led_matrix_frame_scanner dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result       (result),
        .result_valid (result_valid),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    // Observe every transaction on the three channels at the clock edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                sb.check_line(result);
            if (cfg_valid && cfg_ready)
                sb.write_config(cfg_index, cfg_data);
            if (start && !busy)
                sb.note_command(item);
        end
    end

    function automatic item_t make_command(logic [3:0] op, logic [3:0] idx, logic [15:0] data);
        item_t c;
        c.operation = op;
        c.row_index = idx;
        c.row_data  = data;
        return c;
    endfunction

    // Mostly ticks and loads into rows in use, with every other operation mixed in.
    function automatic item_t random_command(int unsigned rows);
        item_t c;
        int pick;
        pick = $urandom_range(0, 99);
        c.row_index = 4'($urandom_range(0, 15));
        c.row_data  = 16'($urandom);
        if (pick < 35)
            c.operation = OP_TICK;
        else if (pick < 65)
        begin
            c.operation = OP_LOAD_ROW;
            if ($urandom_range(0, 4) != 0)
                c.row_index = 4'($urandom_range(0, rows - 1));
        end
        else if (pick < 69)
            c.operation = OP_CLEAR;
        else if (pick < 74)
            c.operation = OP_ROTATE_COLS;
        else if (pick < 79)
            c.operation = OP_ROTATE_ROWS;
        else if (pick < 84)
            c.operation = OP_MIRROR_COLS;
        else if (pick < 89)
            c.operation = OP_MIRROR_ROWS;
        else if (pick < 93)
            c.operation = OP_INVERT;
        else if (pick < 97)
            c.operation = OP_TOGGLE;
        else
            c.operation = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        return c;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int random_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Presents one command and holds it until the block takes it.
    task automatic send_command(input item_t cmd, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= cmd;
        do @(posedge clk); while (busy);
    endtask

    task automatic drain_lines();
        start <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Directed part at the reset sizes, then one random phase per setting.
    initial
    begin
        item_t directed [$];
        logic [CFG_DATA_W-1:0] phase_rows [NUM_PHASES];
        logic [CFG_DATA_W-1:0] phase_cols [NUM_PHASES];
        logic phase_rot [NUM_PHASES];
        int gap;
        int w;

        sb = new();
        phase_rows = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd16, 5'd1, 5'd3, 5'd0};
        phase_cols = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd12, 5'd1, 5'd16, 5'd7, 5'd0};
        phase_rot  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        phase_rows[NUM_PHASES - 1] = 5'($urandom_range(0, 31));
        phase_cols[NUM_PHASES - 1] = 5'($urandom_range(0, 31));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Empty frame, loads in and out of range, every transform, wrap of the scan.
        directed.push_back(make_command(OP_TICK, 4'd0, 16'h0000));
        directed.push_back(make_command(OP_LOAD_ROW, 4'd0, 16'hFFFF));
        directed.push_back(make_command(OP_LOAD_ROW, 4'd7, 16'h8001));
        directed.push_back(make_command(OP_LOAD_ROW, 4'd8, 16'hFFFF));
        directed.push_back(make_command(OP_LOAD_ROW, 4'd15, 16'hA5A5));
        directed.push_back(make_command(OP_LOAD_ROW, 4'd3, 16'h00F0));
        directed.push_back(make_command(OP_ROTATE_COLS, 4'd0, 16'h0000));
        directed.push_back(make_command(OP_ROTATE_ROWS, 4'd0, 16'h0000));
        directed.push_back(make_command(OP_MIRROR_COLS, 4'd0, 16'h0000));
        directed.push_back(make_command(OP_MIRROR_ROWS, 4'd0, 16'h0000));
        directed.push_back(make_command(OP_INVERT, 4'd0, 16'h0000));
        directed.push_back(make_command(OP_TOGGLE, 4'd0, 16'h0000));
        for (int i = 0; i < 8; i++)
            directed.push_back(make_command(OP_TICK, 4'd0, 16'h0000));
        directed.push_back(make_command(OP_UNUSED_LO, 4'd2, 16'h1234));
        directed.push_back(make_command(OP_UNUSED_HI, 4'd15, 16'hFFFF));
        directed.push_back(make_command(OP_CLEAR, 4'd0, 16'h0000));
        directed.push_back(make_command(OP_TICK, 4'd0, 16'h0000));
        directed.push_back(make_command(OP_TOGGLE, 4'd0, 16'h0000));
        foreach (directed[i])
            send_command(directed[i], random_gap());

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // Registers change only once the block has gone quiet.
            drain_lines();
            repeat (SETTLE_CYCLES) @(posedge clk);
            if (p == 3)
                write_register(REG_UNUSED, 5'($urandom_range(0, 31)));
            write_register(REG_ROWS, phase_rows[p]);
            write_register(REG_COLUMNS, phase_cols[p]);
            write_register(REG_ROTATE, {4'($urandom_range(0, 15)), phase_rot[p]});
            cfg_valid <= 1'b0;

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 59) == 0)
                    drain_lines();
                // Some stretches run back to back with no gaps at all.
                gap = ((n % 50) < 15) ? 0 : random_gap();
                send_command(random_command(sb.rows), gap);
            end
        end

        // Let the last lines come out, with a bound on the wait.
        start <= 1'b0;
        w = 0;
        while (w < DRAIN_LIMIT && sb.pending() != 0)
        begin
            @(posedge clk);
            w++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d predicted lines never shown", sb.pending()));

        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #1500000;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
src/lmfs_pkg.sv
src/lmfs_ram.sv
src/lmfs_ctrl.sv
src/lmfs_datapath.sv
src/led_matrix_frame_scanner.sv
src/lmfs_checker.sv
verif/led_matrix_frame_scanner_tb.sv
